/* rtl/focu_pkg.sv */
`default_nettype none
package focu_pkg;

    localparam logic [1:0] ACT_MOVE   = 2'd0;
    localparam logic [1:0] ACT_LOOK   = 2'd1;
    localparam logic [1:0] ACT_PLACE  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic CFG_MOVE_SPEED = 1'b0;
    localparam logic CFG_LOOK_SENS  = 1'b1;

    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [15:0] YAW_RESET   = -16'sd11520;
    localparam logic signed [15:0] PITCH_LIMIT = 16'sd11392;
    localparam logic signed [15:0] QUARTER     = 16'sd11520;
    localparam logic signed [15:0] HALF_TURN   = 16'sd23040;
    localparam logic signed [18:0] FULL_TURN   = 19'sd46080;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ANGLE_TABLE_LEN = 24;

    // Arc tangent of 2^-i in Q.16 degrees.
    function automatic logic signed [22:0] atan_q16(input logic [4:0] i);
        logic signed [22:0] r;
        begin
            case (i)
                5'd0:  r = 23'sd2949120;
                5'd1:  r = 23'sd1740967;
                5'd2:  r = 23'sd919879;
                5'd3:  r = 23'sd466945;
                5'd4:  r = 23'sd234379;
                5'd5:  r = 23'sd117304;
                5'd6:  r = 23'sd58666;
                5'd7:  r = 23'sd29335;
                5'd8:  r = 23'sd14668;
                5'd9:  r = 23'sd7334;
                5'd10: r = 23'sd3667;
                5'd11: r = 23'sd1833;
                5'd12: r = 23'sd917;
                5'd13: r = 23'sd458;
                5'd14: r = 23'sd229;
                5'd15: r = 23'sd115;
                5'd16: r = 23'sd57;
                5'd17: r = 23'sd29;
                5'd18: r = 23'sd14;
                5'd19: r = 23'sd7;
                5'd20: r = 23'sd4;
                5'd21: r = 23'sd2;
                5'd22: r = 23'sd1;
                default: r = 23'sd0;
            endcase
            return r;
        end
    endfunction

    // Datapath operation commands.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;  // capture item, start move or place
    localparam logic [3:0] OP_MOVE    = 4'd2;  // one position component
    localparam logic [3:0] OP_ANGLE   = 4'd3;  // offsets into pitch, yaw split
    localparam logic [3:0] OP_CSTART  = 4'd4;  // seed cordic
    localparam logic [3:0] OP_CITER   = 4'd5;  // one cordic step
    localparam logic [3:0] OP_CDONE   = 4'd6;  // store sine and cosine
    localparam logic [3:0] OP_PROD    = 4'd7;  // one vector product
    localparam logic [3:0] OP_OUT     = 4'd8;  // load output register
    localparam logic [3:0] OP_WRAP    = 4'd9;  // finish the yaw wrap

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;   // component or product index, or seed step
    } focu_cmd_t;

    typedef struct packed {
        logic       cordic_last;
    } focu_stat_t;

endpackage
`default_nettype wire

/* rtl/focu_ctrl.sv */
`default_nettype none
module focu_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_xfer,
    input  wire logic [1:0]         in_action,
    input  wire logic               out_free,
    input  wire focu_pkg::focu_stat_t stat,
    output focu_pkg::focu_cmd_t     cmd,
    output logic                    busy
);
    import focu_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOVE  = 3'd1;
    localparam logic [2:0] ST_CSEED = 3'd2;
    localparam logic [2:0] ST_CITER = 3'd3;
    localparam logic [2:0] ST_CDONE = 3'd4;
    localparam logic [2:0] ST_PROD  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Sequence the item through move, look or place work.
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_xfer) begin
                    cmd.op   = OP_LOAD;
                    sel_next = 2'd0;
                    case (in_action)
                        ACT_MOVE: state_next = ST_MOVE;
                        ACT_LOOK: state_next = ST_CSEED;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_MOVE: begin
                cmd.op = OP_MOVE;
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd2) begin
                    state_next = ST_OUT;
                end
            end
            ST_CSEED: begin
                case (sel_reg)
                    2'd0: begin
                        cmd.op   = OP_ANGLE;
                        sel_next = 2'd1;
                    end
                    2'd1: begin
                        cmd.op   = OP_WRAP;
                        sel_next = 2'd2;
                    end
                    default: begin
                        cmd.op     = OP_CSTART;
                        state_next = ST_CITER;
                    end
                endcase
            end
            ST_CITER: begin
                cmd.op = OP_CITER;
                if (stat.cordic_last) begin
                    state_next = ST_CDONE;
                end
            end
            ST_CDONE: begin
                cmd.op = OP_CDONE;
                sel_next = 2'd0;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.op = OP_PROD;
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd3) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.op = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/focu_datapath.sv */
`default_nettype none
module focu_datapath #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire focu_pkg::focu_cmd_t cmd,
    output focu_pkg::focu_stat_t     stat,
    input  wire logic                cfg_we,
    input  wire logic                cfg_idx,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [1:0]          in_action,
    input  wire logic [1:0]          in_direction,
    input  wire logic [15:0]         in_delta_time,
    input  wire logic signed [15:0]  in_look_dx,
    input  wire logic signed [15:0]  in_look_dy,
    input  wire logic signed [31:0]  in_place_x,
    input  wire logic signed [31:0]  in_place_y,
    input  wire logic signed [31:0]  in_place_z,
    input  wire logic                out_take,
    output logic                     out_valid,
    output logic [239:0]             out_data
);
    import focu_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam logic signed [18:0] WRAP_BIAS = 19'sd184320;
    localparam logic [18:0] RECIP_45 = 19'd372828;

    logic [15:0] speed_reg, sens_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] yaw_reg, pitch_reg;
    logic signed [15:0] front_reg [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] up_reg [3];
    logic [1:0] dir_reg;
    logic [31:0] vel_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic valid_reg;
    logic [239:0] data_reg;
    logic [17:0] wrap_hi_reg;
    logic [9:0] wrap_lo_reg;

    // Two cordic units, yaw and pitch, running side by side.
    logic signed [33:0] cx_reg [2];
    logic signed [33:0] cy_reg [2];
    logic signed [24:0] cz_reg [2];
    logic neg_reg [2];
    logic [SW-1:0] step_reg;
    logic signed [15:0] sy_reg, cyw_reg, sp_reg, cp_reg;

    assign stat.cordic_last = (step_reg == SW'(CORDIC_STEPS - 1));

    // Move step: component times velocity, rounded by 22, saturated.
    logic signed [15:0] mv_comp;
    logic signed [48:0] mv_prod;
    logic signed [33:0] mv_step;
    logic signed [33:0] mv_sum;
    logic mv_sub;
    always_comb begin
        mv_comp = (dir_reg == DIR_FWD || dir_reg == DIR_BACK) ?
                  front_reg[cmd.sel] : right_reg[cmd.sel];
        mv_prod = mv_comp * $signed({1'b0, vel_reg});
        mv_step = 34'((mv_prod + 49'sd2097152) >>> 22);
        mv_sub  = (dir_reg == DIR_BACK || dir_reg == DIR_LEFT);
        mv_sum  = mv_sub ? (34'(pos_reg[cmd.sel]) - mv_step)
                         : (34'(pos_reg[cmd.sel]) + mv_step);
    end
    logic signed [31:0] mv_sat;
    assign mv_sat = (mv_sum > 34'sd2147483647) ? 32'sh7fffffff :
                    (mv_sum < -34'sd2147483648) ? 32'sh80000000 : mv_sum[31:0];

    // Angle update: offsets, pitch clamp and the first half of the yaw wrap.
    logic signed [32:0] ox_full, oy_full;
    logic signed [27:0] ox, oy;
    logic signed [28:0] yaw_sum;
    logic signed [28:0] pit_sum;
    logic signed [15:0] pit_new;
    logic [17:0] wrap_hi;
    always_comb begin
        ox_full = dx_reg * $signed({1'b0, sens_reg});
        oy_full = dy_reg * $signed({1'b0, sens_reg});
        ox = 28'((ox_full + 33'sd16) >>> 5);
        oy = 28'((oy_full + 33'sd16) >>> 5);
        yaw_sum = 29'(yaw_reg) + 29'(ox) + 29'(HALF_TURN);
        // Split the sum into a count of 1024 steps and the low bits. The count
        // is raised by a multiple of 45 to make it positive; 45 * 1024 steps
        // are a full turn, so the wrapped angle does not change.
        wrap_hi = 18'(19'(yaw_sum >>> 10) + WRAP_BIAS);
        pit_sum = 29'(pitch_reg) + 29'(oy);
        pit_new = (pit_sum > 29'(PITCH_LIMIT)) ? PITCH_LIMIT :
                  (pit_sum < -29'(PITCH_LIMIT)) ? -PITCH_LIMIT : pit_sum[15:0];
    end

    // Yaw wrap into [-180, 180): the count is reduced modulo 45 by a
    // reciprocal multiplication that is exact over the count's whole range.
    logic [36:0] wrap_prod;
    logic [12:0] wrap_quo;
    logic [17:0] wrap_sub;
    logic [5:0] wrap_rem;
    logic signed [16:0] yaw_mod;
    logic signed [15:0] yaw_new;
    always_comb begin
        wrap_prod = 37'(wrap_hi_reg) * 37'(RECIP_45);
        wrap_quo  = wrap_prod[36:24];
        wrap_sub  = 18'(wrap_quo) * 18'd45;
        wrap_rem  = 6'(wrap_hi_reg - wrap_sub);
        yaw_mod   = $signed({1'b0, wrap_rem, wrap_lo_reg});
        yaw_new   = 16'(yaw_mod - 17'(HALF_TURN));
    end

    // Cordic seed per unit.
    logic signed [15:0] ang [2];
    logic signed [15:0] ang_f [2];
    logic ang_n [2];
    always_comb begin
        ang[0] = yaw_reg;
        ang[1] = pitch_reg;
        for (int u = 0; u < 2; u++) begin
            ang_f[u] = ang[u];
            ang_n[u] = 1'b0;
            if (ang[u] > QUARTER) begin
                ang_f[u] = ang[u] - HALF_TURN;
                ang_n[u] = 1'b1;
            end else if (ang[u] < -QUARTER) begin
                ang_f[u] = ang[u] + HALF_TURN;
                ang_n[u] = 1'b1;
            end
        end
    end

    // Finish: round, clamp, negate.
    logic signed [15:0] fin_s [2];
    logic signed [15:0] fin_c [2];
    logic signed [18:0] rx, ry;
    always_comb begin
        for (int u = 0; u < 2; u++) begin
            rx = 19'((cx_reg[u] + 34'sd32768) >>> 16);
            ry = 19'((cy_reg[u] + 34'sd32768) >>> 16);
            if (rx > 19'sd16384) rx = 19'sd16384;
            if (rx < -19'sd16384) rx = -19'sd16384;
            if (ry > 19'sd16384) ry = 19'sd16384;
            if (ry < -19'sd16384) ry = -19'sd16384;
            fin_c[u] = neg_reg[u] ? -rx[15:0] : rx[15:0];
            fin_s[u] = neg_reg[u] ? -ry[15:0] : ry[15:0];
        end
    end

    // One Q1.14 product per cycle.
    logic signed [15:0] pa, pb;
    logic signed [31:0] pp;
    logic signed [15:0] pr;
    always_comb begin
        case (cmd.sel)
            2'd0:    begin pa = cyw_reg; pb = cp_reg; end
            2'd1:    begin pa = sy_reg;  pb = cp_reg; end
            2'd2:    begin pa = cyw_reg; pb = sp_reg; end
            default: begin pa = sy_reg;  pb = sp_reg; end
        endcase
        pp = pa * pb;
        pr = 16'((pp + 32'sd8192) >>> 14);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= 16'd640;
            sens_reg  <= 16'd410;
            for (int k = 0; k < 3; k++) pos_reg[k] <= '0;
            yaw_reg   <= YAW_RESET;
            pitch_reg <= '0;
            front_reg[0] <= '0; front_reg[1] <= '0; front_reg[2] <= -ONE_Q14;
            right_reg[0] <= ONE_Q14; right_reg[1] <= '0; right_reg[2] <= '0;
            up_reg[0] <= '0; up_reg[1] <= ONE_Q14; up_reg[2] <= '0;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_MOVE_SPEED) speed_reg <= cfg_data;
                else sens_reg <= cfg_data;
            end
            // The output register fills on a new result and empties on a take.
            if (cmd.op == OP_OUT) begin
                valid_reg <= 1'b1;
            end else if (out_take) begin
                valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD: begin
                    dir_reg <= in_direction;
                    vel_reg <= speed_reg * in_delta_time;
                    dx_reg  <= in_look_dx;
                    dy_reg  <= in_look_dy;
                    if (in_action == ACT_PLACE) begin
                        pos_reg[0] <= in_place_x;
                        pos_reg[1] <= in_place_y;
                        pos_reg[2] <= in_place_z;
                        yaw_reg   <= YAW_RESET;
                        pitch_reg <= '0;
                        front_reg[0] <= '0; front_reg[1] <= '0;
                        front_reg[2] <= -ONE_Q14;
                        right_reg[0] <= ONE_Q14; right_reg[1] <= '0;
                        right_reg[2] <= '0;
                        up_reg[0] <= '0; up_reg[1] <= ONE_Q14; up_reg[2] <= '0;
                    end
                end
                OP_MOVE: pos_reg[cmd.sel] <= mv_sat;
                OP_ANGLE: begin
                    wrap_hi_reg <= wrap_hi;
                    wrap_lo_reg <= yaw_sum[9:0];
                    pitch_reg   <= pit_new;
                end
                OP_WRAP: yaw_reg <= yaw_new;
                OP_CSTART: begin
                    for (int u = 0; u < 2; u++) begin
                        cx_reg[u]  <= CORDIC_GAIN;
                        cy_reg[u]  <= '0;
                        cz_reg[u]  <= 25'(ang_f[u]) * 25'sd512;
                        neg_reg[u] <= ang_n[u];
                    end
                    step_reg <= '0;
                end
                OP_CITER: begin
                    for (int u = 0; u < 2; u++) begin
                        if (cz_reg[u] >= 0) begin
                            cx_reg[u] <= cx_reg[u] - (cy_reg[u] >>> step_reg);
                            cy_reg[u] <= cy_reg[u] + (cx_reg[u] >>> step_reg);
                            cz_reg[u] <= cz_reg[u] - 25'(atan_q16(5'(step_reg)));
                        end else begin
                            cx_reg[u] <= cx_reg[u] + (cy_reg[u] >>> step_reg);
                            cy_reg[u] <= cy_reg[u] - (cx_reg[u] >>> step_reg);
                            cz_reg[u] <= cz_reg[u] + 25'(atan_q16(5'(step_reg)));
                        end
                    end
                    step_reg <= step_reg + SW'(1);
                end
                OP_CDONE: begin
                    sy_reg  <= fin_s[0];
                    cyw_reg <= fin_c[0];
                    sp_reg  <= fin_s[1];
                    cp_reg  <= fin_c[1];
                    front_reg[1] <= fin_s[1];
                    right_reg[0] <= -fin_s[0];
                    right_reg[1] <= '0;
                    right_reg[2] <= fin_c[0];
                    up_reg[1]    <= fin_c[1];
                end
                OP_PROD: begin
                    case (cmd.sel)
                        2'd0:    front_reg[0] <= pr;
                        2'd1:    front_reg[2] <= pr;
                        2'd2:    up_reg[0]    <= -pr;
                        default: up_reg[2]    <= -pr;
                    endcase
                end
                OP_OUT: begin
                    data_reg <= {up_reg[2], up_reg[1], up_reg[0],
                                 right_reg[2], right_reg[1], right_reg[0],
                                 front_reg[2], front_reg[1], front_reg[0],
                                 pos_reg[2], pos_reg[1], pos_reg[0]};
                end
                default: ;
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* rtl/fly_camera_orientation_update_unit.sv */
`default_nettype none
// Channel   | Direction | Contents
// s_axis    | in        | tdata: action, direction, delta_time, look_dx, look_dy,
//           |           |        place_x, place_y, place_z
// m_axis    | out       | tdata: pos_x..z, front_x..z, right_x..z, up_x..z
// cfg       | in        | cfg_index, cfg_data
//
// A move item steps through the position components before the output; a place
// item or an unused action goes straight to the output, and a look item runs the
// two iterative cordic units, which run side by side, before its products.
// One item is worked on at a time; the next is accepted once the result sits
// in the output register, and it may wait there while the next item runs.
// A finished item holds in its last cycle while the output register is full.
// Reset is synchronous on aresetn and restores the start pose and registers.
module fly_camera_orientation_update_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[1:0], direction[3:2], delta_time[19:4], look_dx[35:20],
    // look_dy[51:36], place_x[83:52], place_y[115:84], place_z[147:116]
    input  wire logic [151:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, pos_z (32 each), front_x..z, right_x..z, up_x..z (16 each)
    output logic [239:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import focu_pkg::*;

    focu_cmd_t  cmd;
    focu_stat_t stat;
    logic busy, in_xfer, out_take, out_free;

    assign s_axis_tready = !busy;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign cfg_ready = 1'b1;

    focu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_xfer(in_xfer),
        .in_action(s_axis_tdata[1:0]), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    focu_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data),
        .in_action(s_axis_tdata[1:0]), .in_direction(s_axis_tdata[3:2]),
        .in_delta_time(s_axis_tdata[19:4]),
        .in_look_dx(s_axis_tdata[35:20]), .in_look_dy(s_axis_tdata[51:36]),
        .in_place_x(s_axis_tdata[83:52]), .in_place_y(s_axis_tdata[115:84]),
        .in_place_z(s_axis_tdata[147:116]),
        .out_take(out_take), .out_valid(m_axis_tvalid), .out_data(m_axis_tdata)
    );

endmodule
`default_nettype wire
